// ----- rtl/core/wttu_pkg.sv -----
`default_nettype none

package wttu_pkg;

    // Fixed field widths
    localparam int CODE_BITS   = 21;
    localparam int OFFSET_W    = 16;
    localparam int VALUE_W     = 64;
    localparam int RADIX_W     = 6;
    localparam int DIGIT_W     = 6;

    // Defaults handed to the top level parameters
    localparam int MAX_LENGTH_DEF  = 65536;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
    localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
    localparam logic [RADIX_W-1:0] RADIX_AUTO  = RADIX_W'(0);
    localparam logic [RADIX_W-1:0] RADIX_OCT   = RADIX_W'(8);
    localparam logic [RADIX_W-1:0] RADIX_DEC   = RADIX_W'(10);
    localparam logic [RADIX_W-1:0] RADIX_HEX   = RADIX_W'(16);

    typedef struct packed {
        logic [CODE_BITS-1:0] code_point;
        logic                 starts_string;
    } t_in_req;

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic                overflowed;
        logic                digits_found;
        logic [OFFSET_W-1:0] end_offset;
    } t_out_res;

    // Classified character, as it travels from front to back
    typedef struct packed {
        logic                start;
        logic [OFFSET_W-1:0] offset;
        logic                is_space;
        logic                is_minus;
        logic                is_plus;
        logic                is_zero;
        logic                is_x;
        logic [DIGIT_W-1:0]  digit;
    } t_cls;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SPACE,
        PH_SIGNED,
        PH_ZERO,
        PH_PREFIX,
        PH_DIGITS
    } t_phase;

endpackage

`default_nettype wire

// ----- rtl/core/wttu_front.sv -----
`default_nettype none

module wttu_front
    import wttu_pkg::*;
#(
    parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_in_req i_req,
    input  wire logic    i_push,
    output t_cls         o_cls
);

    localparam int PW = $clog2(MAX_LENGTH);
    localparam logic [PW-1:0] POS_LAST = PW'(MAX_LENGTH - 1);

    localparam logic [CODE_BITS-1:0] CH_TAB   = CODE_BITS'(9);
    localparam logic [CODE_BITS-1:0] CH_CR    = CODE_BITS'(13);
    localparam logic [CODE_BITS-1:0] CH_SPACE = CODE_BITS'(32);
    localparam logic [CODE_BITS-1:0] CH_PLUS  = CODE_BITS'(43);
    localparam logic [CODE_BITS-1:0] CH_MINUS = CODE_BITS'(45);
    localparam logic [CODE_BITS-1:0] CH_0     = CODE_BITS'(48);
    localparam logic [CODE_BITS-1:0] CH_9     = CODE_BITS'(57);
    localparam logic [CODE_BITS-1:0] CH_UA    = CODE_BITS'(65);
    localparam logic [CODE_BITS-1:0] CH_UX    = CODE_BITS'(88);
    localparam logic [CODE_BITS-1:0] CH_UZ    = CODE_BITS'(90);
    localparam logic [CODE_BITS-1:0] CH_LA    = CODE_BITS'(97);
    localparam logic [CODE_BITS-1:0] CH_LX    = CODE_BITS'(120);
    localparam logic [CODE_BITS-1:0] CH_LZ    = CODE_BITS'(122);
    localparam logic [DIGIT_W-1:0]   DIGIT_NONE = '1;

    logic [PW-1:0]          r_next_pos;
    logic [PW-1:0]          n_next_pos;
    logic [PW-1:0]          pos;
    logic [PW+OFFSET_W-1:0] pos_ext;
    logic [CODE_BITS-1:0]   c;
    logic [CODE_BITS-1:0]   diff;

    assign c       = i_req.code_point;
    assign pos     = i_req.starts_string ? '0 : r_next_pos;
    assign pos_ext = {{OFFSET_W{1'b0}}, pos};

    // saturating character index
    assign n_next_pos = (pos < POS_LAST) ? pos + PW'(1) : pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_pos <= '0;
        end else if (i_push) begin
            r_next_pos <= n_next_pos;
        end
    end

    always_comb begin
        diff = '0;
        o_cls.digit = DIGIT_NONE;
        if (c >= CH_0 && c <= CH_9) begin
            diff = c - CH_0;
            o_cls.digit = diff[DIGIT_W-1:0];
        end else if (c >= CH_UA && c <= CH_UZ) begin
            diff = c - CH_UA + CODE_BITS'(10);
            o_cls.digit = diff[DIGIT_W-1:0];
        end else if (c >= CH_LA && c <= CH_LZ) begin
            diff = c - CH_LA + CODE_BITS'(10);
            o_cls.digit = diff[DIGIT_W-1:0];
        end
        o_cls.start    = i_req.starts_string;
        o_cls.offset   = pos_ext[OFFSET_W-1:0];
        o_cls.is_space = (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE;
        o_cls.is_minus = c == CH_MINUS;
        o_cls.is_plus  = c == CH_PLUS;
        o_cls.is_zero  = c == CH_0;
        o_cls.is_x     = c == CH_LX || c == CH_UX;
    end

endmodule

`default_nettype wire

// ----- rtl/core/wttu_queue.sv -----
`default_nettype none

module wttu_queue
    import wttu_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cls i_data,
    output logic      o_full,
    input  wire logic i_pop,
    output t_cls      o_data,
    output logic      o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_cls          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = r_count == CNT_FULL;
    assign o_empty = r_count == '0;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("queue written while full");

    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue read while empty");

    a_ptrs_meet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers apart while empty");

endmodule

`default_nettype wire

// ----- rtl/core/wttu_back.sv -----
`default_nettype none

module wttu_back
    import wttu_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [RADIX_W-1:0] i_radix,
    input  wire t_cls               i_cls,
    input  wire logic               i_empty,
    output logic                    o_pop,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output t_out_res                o_out_res
);

    localparam int PROD_W = VALUE_W + RADIX_W;

    t_phase             r_phase, n_phase;
    logic               r_minus, n_minus;
    logic [RADIX_W-1:0] r_base,  n_base;
    logic [VALUE_W-1:0] r_acc,   n_acc;
    logic               r_ovf,   n_ovf;
    logic               r_dig,   n_dig;
    logic               r_out_valid;
    t_out_res           r_out_res;

    t_phase             ph;
    logic               minus_in;
    logic [RADIX_W-1:0] base_in;
    logic [VALUE_W-1:0] acc_in;
    logic               ovf_in;
    logic               dig_in;
    logic               first;
    logic               prefix_mode;
    logic               do_step;
    logic               do_emit;
    logic               step_valid;
    logic [RADIX_W-1:0] step_base;
    logic [PROD_W-1:0]  prod;
    logic               emit_hd;
    logic [OFFSET_W-1:0] emit_off;
    t_out_res           res;

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out_res;
    assign o_pop       = !i_empty && (!r_out_valid || !i_out_stall);

    always_comb begin
        // a start marker resets the parse before the character is looked at
        ph       = i_cls.start ? PH_SPACE : r_phase;
        minus_in = i_cls.start ? 1'b0 : r_minus;
        base_in  = i_cls.start ? i_radix : r_base;
        acc_in   = i_cls.start ? '0 : r_acc;
        ovf_in   = i_cls.start ? 1'b0 : r_ovf;
        dig_in   = i_cls.start ? 1'b0 : r_dig;

        n_phase = ph;
        n_minus = minus_in;
        n_base  = base_in;
        n_acc   = acc_in;
        n_ovf   = ovf_in;
        n_dig   = dig_in;

        first       = 1'b0;
        prefix_mode = 1'b0;
        do_step     = 1'b0;
        do_emit     = 1'b0;
        step_base   = base_in;
        emit_hd     = dig_in;
        emit_off    = i_cls.offset;

        unique case (ph)
            PH_IDLE: begin
            end
            PH_SPACE: begin
                if (i_cls.is_space) begin
                    n_phase = PH_SPACE;
                end else if (i_cls.is_minus) begin
                    n_minus = 1'b1;
                    n_phase = PH_SIGNED;
                end else if (i_cls.is_plus) begin
                    n_phase = PH_SIGNED;
                end else begin
                    first = 1'b1;
                end
            end
            PH_SIGNED: begin
                first = 1'b1;
            end
            PH_ZERO: begin
                if (i_cls.is_x) begin
                    n_base  = RADIX_HEX;
                    n_phase = PH_PREFIX;
                end else begin
                    step_base = (base_in == RADIX_AUTO) ? RADIX_OCT : base_in;
                    do_step   = 1'b1;
                end
            end
            PH_PREFIX: begin
                prefix_mode = 1'b1;
                do_step     = 1'b1;
            end
            PH_DIGITS: begin
                do_step = 1'b1;
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        // leading zero may open a 0x prefix or an octal number
        if (first) begin
            if ((base_in == RADIX_AUTO || base_in == RADIX_HEX) && i_cls.is_zero) begin
                n_dig   = 1'b1;
                n_phase = PH_ZERO;
            end else begin
                step_base = (base_in == RADIX_AUTO) ? RADIX_DEC : base_in;
                do_step   = 1'b1;
            end
        end

        step_valid = step_base >= RADIX_MIN && step_base <= RADIX_MAX
                     && i_cls.digit < step_base;

        // 64 x 6 multiply-add; any carry out of 64 bits is overflow
        prod = PROD_W'(acc_in) * PROD_W'(step_base) + PROD_W'(i_cls.digit);

        if (do_step) begin
            n_base = step_base;
            if (step_valid) begin
                if (ovf_in || prod[PROD_W-1:VALUE_W] != '0) begin
                    n_ovf = 1'b1;
                end else begin
                    n_acc = prod[VALUE_W-1:0];
                end
                n_dig   = 1'b1;
                n_phase = PH_DIGITS;
            end else begin
                do_emit = 1'b1;
                if (prefix_mode) begin
                    // bare 0x: the number ends at the x
                    emit_hd  = 1'b1;
                    emit_off = i_cls.offset - OFFSET_W'(1);
                end
                n_phase = PH_IDLE;
            end
        end

        res.value        = ovf_in ? '1 : (minus_in ? '0 - acc_in : acc_in);
        res.overflowed   = ovf_in;
        res.digits_found = emit_hd;
        res.end_offset   = emit_hd ? emit_off : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_minus     <= 1'b0;
            r_base      <= '0;
            r_acc       <= '0;
            r_ovf       <= 1'b0;
            r_dig       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase <= n_phase;
                r_minus <= n_minus;
                r_base  <= n_base;
                r_acc   <= n_acc;
                r_ovf   <= n_ovf;
                r_dig   <= n_dig;
            end
            if (!r_out_valid || !i_out_stall) begin
                r_out_valid <= o_pop && do_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && do_emit) begin
            r_out_res <= res;
        end
    end

    a_emit_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && do_emit) |=> (r_phase == PH_IDLE))
        else $error("parse still active after result");

    a_ovf_has_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> r_dig)
        else $error("overflow without digits");

    a_prefix_hex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PREFIX) |-> (r_base == RADIX_HEX))
        else $error("prefix phase without base 16");

    a_no_load_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !o_pop)
        else $error("queue popped while result held");

endmodule

`default_nettype wire

// ----- rtl/core/wide_text_to_unsigned_parser.sv -----
// Streaming strtoul-style parser: text in, one unsigned 64-bit number out.
//
// Input channel (i_in_valid / o_in_stall / i_in_req): one wide character per
// request. starts_string marks index 0 of a new string and drops any parse
// in progress. Characters outside a string are swallowed with no result.
// Output channel (o_out_valid / i_out_stall / o_out_res): one result per
// string, given at the first character that is not a digit of the base.
// Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data): the radix, always
// ready; it is sampled when a string starts, so write it only while idle.
//
// Throughput is one character per cycle when not stalled. The front end
// classifies and tags each character with its index, a small queue
// decouples it from the back end, whose 64 x 6 multiply-add with carry-out
// overflow test is the only loop: one character per cycle through it. The
// stopping character goes through the queue, then the result register, to
// o_out_valid. A stalled result sits in the output register while the
// queue keeps filling; o_in_stall rises only when the queue is full.
// Reset: radix returns to 10, the parser goes idle, queue and output empty.
`default_nettype none

module wide_text_to_unsigned_parser
    import wttu_pkg::*;
#(
    parameter int MAX_LENGTH  = MAX_LENGTH_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire t_in_req            i_in_req,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output t_out_res                o_out_res,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [RADIX_W-1:0] i_cfg_data
);

    logic [RADIX_W-1:0] r_radix;
    logic               push;
    logic               pop;
    logic               full;
    logic               empty;
    t_cls               front_cls;
    t_cls               queue_cls;

    // radix register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_radix <= i_cfg_data;
        end
    end

    // accept whenever the queue has room
    assign o_in_stall = full;
    assign push       = i_in_valid && !full;

    wttu_front #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_in_req),
        .i_push  (push),
        .o_cls   (front_cls)
    );

    wttu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cls),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (queue_cls),
        .o_empty (empty)
    );

    wttu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_radix     (r_radix),
        .i_cls       (queue_cls),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_res   (o_out_res)
    );

endmodule

`default_nettype wire
